### sv/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is never true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CHK(label, !(cond), msg)

`endif

### sv/csr_pkg.sv
// Shared widths and types for the complex square root pipeline.
package csr_pkg;

  localparam int IN_W       = 32;
  localparam int ROOT_W     = 32;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int STEPS      = ROOT_W;
  localparam int HALF_SHIFT = 15;
  localparam int SUM_W      = IN_W + 1;
  localparam int OUT_RE_W   = 24;
  localparam int OUT_IM_W   = 25;

  typedef struct packed {
    logic signed [IN_W-1:0] re;
    logic                   neg;
  } side_t;

endpackage

### sv/csr_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
module csr_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       valid_in,
  input  logic [csr_pkg::RAD_W-1:0]  rad_in,
  input  csr_pkg::side_t             side_in,
  output logic                       valid_out,
  output logic [csr_pkg::ROOT_W-1:0] root,
  output csr_pkg::side_t             side_out
);

  typedef struct packed {
    logic [csr_pkg::REM_W-1:0]  rem;
    logic [csr_pkg::ROOT_W-1:0] root;
    logic [csr_pkg::RAD_W-1:0]  rad;
    csr_pkg::side_t             side;
  } sq_data_t;

  sq_data_t stg      [1:csr_pkg::STEPS];
  logic     vld      [1:csr_pkg::STEPS];
  sq_data_t src      [0:csr_pkg::STEPS-1];
  logic     src_v    [0:csr_pkg::STEPS-1];
  sq_data_t stg_next [0:csr_pkg::STEPS-1];

  always_comb begin
    logic [csr_pkg::REM_W-1:0] cur;
    logic [csr_pkg::REM_W-1:0] trial;
    src[0].rem  = '0;
    src[0].root = '0;
    src[0].rad  = rad_in;
    src[0].side = side_in;
    src_v[0]    = valid_in;
    for (int i = 1; i < csr_pkg::STEPS; i++) begin
      src[i]   = stg[i];
      src_v[i] = vld[i];
    end
    for (int i = 0; i < csr_pkg::STEPS; i++) begin
      cur   = {src[i].rem[csr_pkg::REM_W-3:0], src[i].rad[csr_pkg::RAD_W-1 -: 2]};
      trial = {src[i].root, 2'b01};
      stg_next[i].rad  = {src[i].rad[csr_pkg::RAD_W-3:0], 2'b00};
      stg_next[i].side = src[i].side;
      if (cur >= trial) begin
        stg_next[i].rem  = cur - trial;
        stg_next[i].root = {src[i].root[csr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        stg_next[i].rem  = cur;
        stg_next[i].root = {src[i].root[csr_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= csr_pkg::STEPS; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < csr_pkg::STEPS; i++) vld[i+1] <= src_v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < csr_pkg::STEPS; i++) stg[i+1] <= stg_next[i];
    end
  end

  assign valid_out = vld[csr_pkg::STEPS];
  assign root      = stg[csr_pkg::STEPS].root;
  assign side_out  = stg[csr_pkg::STEPS].side;

endmodule

### sv/csr_front.sv
// Front stages: absolute values, squares and the squared magnitude.
module csr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             valid_in,
  input  logic signed [csr_pkg::IN_W-1:0]  real_in,
  input  logic signed [csr_pkg::IN_W-1:0]  imag_in,
  output logic                             valid_out,
  output logic [csr_pkg::RAD_W-1:0]        rad,
  output csr_pkg::side_t                   side_out
);

  logic                            v1;
  logic                            v2;
  logic [csr_pkg::IN_W-1:0]        are;
  logic [csr_pkg::IN_W-1:0]        aim;
  csr_pkg::side_t                  side1;
  logic [csr_pkg::RAD_W-1:0]       sq_re;
  logic [csr_pkg::RAD_W-1:0]       sq_im;
  csr_pkg::side_t                  side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      valid_out <= 1'b0;
    end else if (adv) begin
      v1        <= valid_in;
      v2        <= v1;
      valid_out <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      are        <= real_in[csr_pkg::IN_W-1] ? (-real_in) : real_in;
      aim        <= imag_in[csr_pkg::IN_W-1] ? (-imag_in) : imag_in;
      side1.re   <= real_in;
      side1.neg  <= imag_in[csr_pkg::IN_W-1];
      sq_re      <= are * are;
      sq_im      <= aim * aim;
      side2      <= side1;
      rad        <= sq_re + sq_im;
      side_out   <= side2;
    end
  end

endmodule

### sv/complex_square_root.sv
// Complex principal square root of a Q16.16 item, fully pipelined.
// Items go through the front, magnitude root, combine register, both roots, output register.
// One item per cycle when not stalled; each of the three roots resolves one bit per stage.
// A stalled output freezes the whole pipeline; sample_stall follows it.
// Reset clears all valid bits; data registers are not reset.
module complex_square_root (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [csr_pkg::IN_W-1:0]      real_in,
  input  logic signed [csr_pkg::IN_W-1:0]      imag_in,
  output logic                                 root_valid,
  input  logic                                 root_stall,
  output logic [csr_pkg::OUT_RE_W-1:0]         root_real,
  output logic signed [csr_pkg::OUT_IM_W-1:0]  root_imag
);

  logic                         adv;
  logic                         f_valid;
  logic [csr_pkg::RAD_W-1:0]    f_rad;
  csr_pkg::side_t               f_side;
  logic                         m_valid;
  logic [csr_pkg::ROOT_W-1:0]   m_root;
  csr_pkg::side_t               m_side;
  logic signed [csr_pkg::SUM_W:0] m_ext;
  logic signed [csr_pkg::SUM_W:0] re_ext;
  logic signed [csr_pkg::SUM_W:0] sum_ext;
  logic signed [csr_pkg::SUM_W:0] diff_ext;
  logic                         c_valid;
  logic [csr_pkg::RAD_W-1:0]    c_rad_re;
  logic [csr_pkg::RAD_W-1:0]    c_rad_im;
  csr_pkg::side_t               c_side;
  logic                         r_valid;
  logic [csr_pkg::ROOT_W-1:0]   r_root;
  csr_pkg::side_t               r_side;
  logic [csr_pkg::ROOT_W-1:0]   i_root;
  logic [csr_pkg::OUT_IM_W-1:0] mag_im;

  assign adv          = !root_valid || !root_stall;
  assign sample_stall = !adv;

  csr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .valid_in  (sample_valid),
    .real_in   (real_in),
    .imag_in   (imag_in),
    .valid_out (f_valid),
    .rad       (f_rad),
    .side_out  (f_side)
  );

  csr_sqrt u_mag (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .valid_in  (f_valid),
    .rad_in    (f_rad),
    .side_in   (f_side),
    .valid_out (m_valid),
    .root      (m_root),
    .side_out  (m_side)
  );

  assign m_ext    = {2'b00, m_root};
  assign re_ext   = {{2{m_side.re[csr_pkg::IN_W-1]}}, m_side.re};
  assign sum_ext  = m_ext + re_ext;
  assign diff_ext = m_ext - re_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_rad_re <= {{(csr_pkg::RAD_W - csr_pkg::SUM_W - csr_pkg::HALF_SHIFT){1'b0}},
                   sum_ext[csr_pkg::SUM_W-1:0], {csr_pkg::HALF_SHIFT{1'b0}}};
      c_rad_im <= {{(csr_pkg::RAD_W - csr_pkg::SUM_W - csr_pkg::HALF_SHIFT){1'b0}},
                   diff_ext[csr_pkg::SUM_W-1:0], {csr_pkg::HALF_SHIFT{1'b0}}};
      c_side   <= m_side;
    end
  end

  csr_sqrt u_root_re (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .valid_in  (c_valid),
    .rad_in    (c_rad_re),
    .side_in   (c_side),
    .valid_out (r_valid),
    .root      (r_root),
    .side_out  (r_side)
  );

  csr_sqrt u_root_im (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .valid_in  (c_valid),
    .rad_in    (c_rad_im),
    .side_in   (c_side),
    .valid_out (),
    .root      (i_root),
    .side_out  ()
  );

  assign mag_im = {1'b0, i_root[csr_pkg::OUT_RE_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (adv) begin
      root_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root_real <= r_root[csr_pkg::OUT_RE_W-1:0];
      root_imag <= r_side.neg ? (-mag_im) : mag_im;
    end
  end

endmodule

### sv/csr_checker.sv
// Port-level checker for the complex square root and its bind.
`include "assert_macros.svh"

module csr_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 sample_valid,
  input logic                                 sample_stall,
  input logic signed [csr_pkg::IN_W-1:0]      real_in,
  input logic signed [csr_pkg::IN_W-1:0]      imag_in,
  input logic                                 root_valid,
  input logic                                 root_stall,
  input logic [csr_pkg::OUT_RE_W-1:0]         root_real,
  input logic signed [csr_pkg::OUT_IM_W-1:0]  root_imag
);

  logic in_seen;

  assign in_seen = sample_valid && (real_in == real_in) && (imag_in == imag_in);

  `ASSERT_CHK(a_out_hold, root_valid && root_stall |=> root_valid && $stable(root_real) && $stable(root_imag), "stalled result item changed")
  `ASSERT_CHK(a_stall_cause, in_seen && sample_stall |-> root_valid && root_stall, "input stalled without a blocked result item")
  `ASSERT_CHK(a_reset_empty, $past(rst) |-> !root_valid, "result item shown right after reset")
  `ASSERT_NEVER(a_free_stall, sample_stall && !root_valid, "input stalled with an empty output")

endmodule

bind complex_square_root csr_checker u_csr_checker (.*);
